// ===== rtl/afl_pkg.sv =====
// Shared types and constants for the animation frame lookup block.
// No dependencies; imported by afl_mod_unit and animation_frame_lookup_top.
package afl_pkg;

  localparam int MAG_BITS   = 32;
  localparam int CNT_BITS   = $clog2(MAG_BITS);
  localparam int LEFT_BITS  = 16;
  localparam int INDEX_BITS = 6;

  localparam logic [LEFT_BITS-1:0] LEFT_HOLD = '1;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_FETCH,
    S_WALK,
    S_DONE
  } afl_state_t;

endpackage

// ===== rtl/afl_mod_unit.sv =====
// Iterative restoring remainder unit: one dividend bit per cycle.
// Depends on afl_pkg for the dividend width and step counter width.
module afl_mod_unit
  import afl_pkg::*;
#(
  parameter int DIV_BITS = 22
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [MAG_BITS-1:0] dividend,
  input  logic [DIV_BITS-1:0] divisor,
  output logic                done,
  output logic [DIV_BITS-1:0] rem
);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [MAG_BITS-1:0] quo;
  logic [DIV_BITS:0]   trial;
  logic [DIV_BITS:0]   diff;

  assign trial = {rem, quo[MAG_BITS-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(MAG_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= diff[DIV_BITS] ? trial[DIV_BITS-1:0] : diff[DIV_BITS-1:0];
      quo <= {quo[MAG_BITS-2:0], 1'b0};
    end
  end

endmodule

// ===== rtl/animation_frame_lookup_top.sv =====
// Clear, append, no-op and unwalked lookups give their result in the cycle after acceptance;
// a walked lookup adds a table fetch state and a walk state that visits one frame per cycle,
// and a looping lookup first runs the remainder unit in S_MOD before the fetch.
// Throughput: one transaction at a time; in_ready returns the cycle after the result leaves.
// Reset (rst, synchronous): table empty, span zero, single_shot 0; no clearing pass.
// Depends on afl_pkg and afl_mod_unit.
module animation_frame_lookup_top
  import afl_pkg::*;
#(
  parameter int MAX_FRAMES    = 64,
  parameter int DURATION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           action,
  input  logic [15:0]          frame_duration,
  input  logic signed [31:0]   query_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [5:0]           frame_index,
  output logic [15:0]          time_left,
  output logic                 held,
  output logic [1:0]           status
);

  localparam int IW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW   = $clog2(MAX_FRAMES + 1);
  localparam int DW   = DURATION_BITS;
  localparam int SW   = DW + CW;
  localparam int CMPW = (SW > MAG_BITS) ? SW : MAG_BITS;

  afl_state_t state, state_next;

  logic [DW-1:0]       mem [MAX_FRAMES];
  logic [DW-1:0]       rdata;
  logic [IW-1:0]       rd_addr;
  logic [CW-1:0]       frame_total;
  logic [SW-1:0]       span;
  logic                single_shot;
  logic                neg;
  logic [SW-1:0]       t;
  logic [SW-1:0]       cum;
  logic [IW-1:0]       idx;

  logic                in_accept;
  logic                neg_in;
  logic [MAG_BITS-1:0] mag_in;
  logic [47:0]         dur_ext;
  logic [DW-1:0]       dur;
  logic                full;
  logic                over_span;
  logic                lk_go;
  logic                mod_start;
  logic                mod_done;
  logic [SW-1:0]       mod_rem;
  logic [CW-1:0]       last_idx;
  logic                at_last;
  logic [CMPW-1:0]     sum_w;
  logic [CMPW-1:0]     t_w;
  logic [CMPW-1:0]     left_w;
  logic                hit;
  logic [15:0]         total_ext;
  logic [15:0]         last_ext;
  logic [15:0]         idx_ext;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && in_ready;
  assign neg_in    = query_time[MAG_BITS-1];
  assign mag_in    = neg_in ? (~query_time + 1'b1) : query_time;
  assign dur_ext   = {32'd0, frame_duration};
  assign dur       = dur_ext[DW-1:0];
  assign full      = (frame_total >= CW'(MAX_FRAMES));
  assign over_span = CMPW'(mag_in) > CMPW'(span);
  assign last_idx  = frame_total - 1'b1;
  assign at_last   = CW'(idx) == last_idx;
  assign sum_w     = CMPW'(cum) + CMPW'(rdata);
  assign t_w       = CMPW'(t);
  assign left_w    = sum_w - t_w;
  assign hit       = sum_w >= t_w;
  assign total_ext = 16'(frame_total);
  assign last_ext  = 16'(last_idx);
  assign idx_ext   = 16'(idx);

  assign lk_go = (action == ACT_LOOKUP) && (frame_total != '0) && (span != '0)
                 && !(single_shot && (neg_in || over_span));

  afl_mod_unit #(
    .DIV_BITS (SW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mag_in),
    .divisor  (span),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (lk_go) state_next = single_shot ? S_FETCH : S_MOD;
          else       state_next = S_DONE;
        end
      end
      S_MOD: begin
        if (mod_done) state_next = S_FETCH;
      end
      S_FETCH: state_next = S_WALK;
      S_WALK: begin
        if (hit || at_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_DONE);
    mod_start = in_accept && lk_go && !single_shot;
    rd_addr   = (state == S_WALK) ? (idx + 1'b1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_total <= '0;
      span        <= '0;
      single_shot <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) single_shot <= cfg_data;
      if (in_accept) begin
        case (action)
          ACT_CLEAR: begin
            frame_total <= '0;
            span        <= '0;
          end
          ACT_APPEND: begin
            if (!full) begin
              frame_total <= frame_total + 1'b1;
              span        <= span + SW'(dur);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (action == ACT_APPEND) && !full) mem[frame_total[IW-1:0]] <= dur;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          neg         <= neg_in;
          t           <= SW'(mag_in);
          cum         <= '0;
          idx         <= '0;
          frame_index <= '0;
          time_left   <= '0;
          held        <= 1'b0;
          status      <= ST_OK;
          case (action)
            ACT_APPEND: begin
              if (full) status <= ST_FULL;
              else      frame_index <= total_ext[INDEX_BITS-1:0];
            end
            ACT_LOOKUP: begin
              if (frame_total == '0) begin
                status <= ST_EMPTY;
              end else if (single_shot && neg_in) begin
                time_left <= LEFT_HOLD;
                held      <= 1'b1;
              end else if (single_shot && over_span) begin
                frame_index <= last_ext[INDEX_BITS-1:0];
                time_left   <= LEFT_HOLD;
                held        <= 1'b1;
              end else if (span == '0) begin
                frame_index <= last_ext[INDEX_BITS-1:0];
                status      <= ST_ZERO;
              end
            end
            default: ;
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) t <= neg ? (span - mod_rem) : mod_rem;
      end
      S_WALK: begin
        if (hit) begin
          frame_index <= idx_ext[INDEX_BITS-1:0];
          time_left   <= left_w[LEFT_BITS-1:0];
        end else if (at_last) begin
          frame_index <= last_ext[INDEX_BITS-1:0];
          time_left   <= '0;
        end else begin
          cum <= sum_w[SW-1:0];
          idx <= idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    frame_total <= CW'(MAX_FRAMES))
    else $error("frame count beyond table depth");

  a_walk_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (CW'(idx) < frame_total))
    else $error("table walk past last frame");

  a_mod_done_state: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_MOD))
    else $error("remainder finished outside its state");

  a_time_in_span: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (t_w <= CMPW'(span)))
    else $error("normalized time exceeds span");
`endif

endmodule
